// ----- sv/mh_pkg.sv -----
// shared types, constants and angle-table functions of the compass heading block
// no dependencies; every other file of the block imports this package
`timescale 1ns / 1ps

package mh_pkg;

  localparam int unsigned CORDIC_ITERATIONS = 28;
  localparam int unsigned SH_W      = $clog2(CORDIC_ITERATIONS);
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HEAD_W    = 27;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ANG_FRAC  = 56;   // angle unit is 2^-56 rad
  localparam int unsigned XY_SHIFT  = 40;   // x and y prescale
  localparam int unsigned XY_W      = 59;   // holds 2^55 times the cordic gain times sqrt 2
  localparam int unsigned Z_W       = 60;   // holds pi plus the sum of all step angles
  localparam int unsigned LO_BITS   = 28;   // split point of the angle magnitude
  localparam int unsigned RAD_W     = 30;
  localparam logic [RAD_W-1:0] RAD_TO_UNITS_X100 = 30'd572957795;
  localparam int unsigned V_W       = 32;   // angle times 1.8e7 over pi, scaled by 100
  localparam logic [V_W-1:0] DIV100_RECIP = 32'd2748779070;  // ceil(2^38 / 100)
  localparam int unsigned DIV100_SHIFT = 38;
  localparam logic [HEAD_W-1:0] FULL_TURN = 27'd36000000;
  localparam logic [9:0] DECL_SCALE = 10'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_CORR = 2'd0,
    REG_Y_CORR = 2'd1,
    REG_DECL   = 2'd2
  } cfg_reg_e;

  // corrected readings and zero-vector flag riding along with the rotation
  typedef struct packed {
    logic [RAW_W-1:0] corr_x;
    logic [RAW_W-1:0] corr_y;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } cordic_t;

  typedef struct packed {
    logic [RAW_W-1:0]  corr_x;
    logic [RAW_W-1:0]  corr_y;
    logic [HEAD_W-1:0] heading;
  } result_t;

  // pi/4 by machin's formula, each series term truncated
  function automatic logic [63:0] quarter_pi();
    logic [63:0] p5;
    logic [63:0] p239;
    logic [63:0] s5;
    logic [63:0] s239;
    logic [63:0] term;
    p5   = (64'd1 << ANG_FRAC) / 64'd5;
    p239 = (64'd1 << ANG_FRAC) / 64'd239;
    s5   = 64'd0;
    s239 = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p5 != 64'd0) begin
        term = p5 / 64'(2 * k + 1);
        if ((k % 2) == 1) s5 = s5 - term;
        else s5 = s5 + term;
        p5 = p5 / 64'd25;
      end
      if (p239 != 64'd0) begin
        term = p239 / 64'(2 * k + 1);
        if ((k % 2) == 1) s239 = s239 - term;
        else s239 = s239 + term;
        p239 = p239 / 64'd57121;
      end
    end
    return (s5 << 2) - s239;
  endfunction

  // atan(2^-i) as a truncated taylor sum; i = 0 gives the machin pi/4
  function automatic logic [63:0] atan_pow2(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned m;
    sum = 64'd0;
    if (i == 0) begin
      sum = quarter_pi();
    end else begin
      for (int unsigned k = 0; k <= ANG_FRAC; k++) begin
        m = i * (2 * k + 1);
        if (m <= ANG_FRAC) begin
          term = (64'd1 << (ANG_FRAC - m)) / 64'(2 * k + 1);
          if ((k % 2) == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  localparam logic [Z_W-1:0] PI_Z = Z_W'(quarter_pi() << 2);

endpackage

// ----- sv/mh_prep.sv -----
// input stage: correction add, half-plane fold and prescale into the cordic chain
// depends on mh_pkg
`timescale 1ns / 1ps

module mh_prep import mh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [BYTE_W-1:0] x_high_byte_i,
  input  logic [BYTE_W-1:0] x_low_byte_i,
  input  logic [BYTE_W-1:0] y_high_byte_i,
  input  logic [BYTE_W-1:0] y_low_byte_i,
  input  logic [RAW_W-1:0]  x_corr_i,
  input  logic [RAW_W-1:0]  y_corr_i,
  output cordic_t           cell_o
);

  logic [RAW_W-1:0]     xw;
  logic [RAW_W-1:0]     yw;
  logic signed [RAW_W:0] xs;
  logic signed [RAW_W:0] ys;
  logic signed [Z_W-1:0] z0;
  cordic_t              cell_d;
  cordic_t              data_q;
  logic                 valid_q;

  always_comb begin
    xw = {x_high_byte_i, x_low_byte_i} + x_corr_i;
    yw = {y_high_byte_i, y_low_byte_i} + y_corr_i;
    xs = signed'({xw[RAW_W-1], xw});
    ys = signed'({yw[RAW_W-1], yw});
    z0 = '0;
    // left half plane: rotate by pi first, sign taken from the original y
    if (xw[RAW_W-1]) begin
      xs = -xs;
      ys = -ys;
      z0 = yw[RAW_W-1] ? signed'(Z_W'(-PI_Z)) : signed'(PI_Z);
    end
    cell_d             = '0;
    cell_d.valid       = valid_i;
    cell_d.x           = XY_W'(xs) <<< XY_SHIFT;
    cell_d.y           = XY_W'(ys) <<< XY_SHIFT;
    cell_d.z           = z0;
    cell_d.side.corr_x = xw;
    cell_d.side.corr_y = yw;
    cell_d.side.zero   = (xw == '0) && (yw == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

// ----- sv/mh_cell.sv -----
// one vectoring cordic micro-rotation with its pipeline register
// depends on mh_pkg; shift amount and step angle are tied off per cell by the top
`timescale 1ns / 1ps

module mh_cell import mh_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [SH_W-1:0] shift_i,
  input  logic [Z_W-1:0] angle_i,
  input  cordic_t        cell_i,
  output cordic_t        cell_o
);

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  logic signed [Z_W-1:0]  ang;
  cordic_t                cell_d;
  cordic_t                data_q;
  logic                   valid_q;

  always_comb begin
    x_in   = cell_i.x;
    y_in   = cell_i.y;
    x_sh   = x_in >>> shift_i;
    y_sh   = y_in >>> shift_i;
    ang    = signed'(angle_i);
    cell_d = cell_i;
    // drive y toward zero, accumulating the angle turned
    if (!y_in[XY_W-1]) begin
      cell_d.x = x_in + y_sh;
      cell_d.y = y_in - x_sh;
      cell_d.z = cell_i.z + ang;
    end else begin
      cell_d.x = x_in - y_sh;
      cell_d.y = y_in + x_sh;
      cell_d.z = cell_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

// ----- sv/mh_post.sv -----
// four-stage conversion of the cordic angle to 1e-5 degree units plus declination
// depends on mh_pkg
`timescale 1ns / 1ps

module mh_post import mh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cordic_t           cell_i,
  input  logic [HEAD_W-1:0] decl_scaled_i,
  output logic              valid_o,
  output result_t           res_o
);

  localparam int unsigned AH_W = Z_W - LO_BITS;
  localparam int unsigned P1_W = AH_W + RAD_W;
  localparam int unsigned P0_W = LO_BITS + RAD_W;
  localparam int unsigned S_W  = P1_W + 1;
  localparam int unsigned PR_W = 2 * V_W;
  localparam int unsigned Q_W  = PR_W - DIV100_SHIFT;

  // stage 1: magnitude split and two partial products
  logic                 neg;
  logic [Z_W-1:0]       mag;
  logic [P1_W-1:0]      p1_d;
  logic [P0_W-1:0]      p0_d;
  logic [3:0]           valid_q;
  logic [P1_W-1:0]      p1_q;
  logic [P0_W-1:0]      p0_q;
  side_t                side1_q;
  logic                 neg1_q;
  // stage 2: recombine and drop the 2^56 scale
  logic [S_W-1:0]       sum;
  logic [V_W-1:0]       v_q;
  side_t                side2_q;
  logic                 neg2_q;
  // stage 3: divide by 100 through the reciprocal
  logic [PR_W-1:0]      prod_q;
  side_t                side3_q;
  logic                 neg3_q;
  // stage 4: sign, wrap to a full turn, zero vector and declination
  logic [Q_W-1:0]       q;
  logic [HEAD_W-1:0]    turn;
  result_t              res_d;
  result_t              res_q;

  always_comb begin
    neg  = cell_i.z[Z_W-1];
    mag  = neg ? Z_W'(-cell_i.z) : Z_W'(cell_i.z);
    p1_d = P1_W'(mag[Z_W-1:LO_BITS]) * P1_W'(RAD_TO_UNITS_X100);
    p0_d = P0_W'(mag[LO_BITS-1:0]) * P0_W'(RAD_TO_UNITS_X100);
  end

  // the converged angle stays within pi, so the scaled value fits V_W bits
  assign sum = S_W'(p1_q) + S_W'(p0_q >> LO_BITS);

  always_comb begin
    q    = prod_q[DIV100_SHIFT +: Q_W];
    turn = (neg3_q && (q != '0)) ? FULL_TURN - HEAD_W'(q) : HEAD_W'(q);
    if (side3_q.zero) begin
      turn = '0;
    end
    res_d.corr_x  = side3_q.corr_x;
    res_d.corr_y  = side3_q.corr_y;
    res_d.heading = turn + decl_scaled_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], cell_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= p1_d;
      p0_q    <= p0_d;
      side1_q <= cell_i.side;
      neg1_q  <= neg;
      v_q     <= sum[LO_BITS +: V_W];
      side2_q <= side1_q;
      neg2_q  <= neg1_q;
      prod_q  <= PR_W'(v_q) * PR_W'(DIV100_RECIP);
      side3_q <= side2_q;
      neg3_q  <= neg2_q;
      res_q   <= res_d;
    end
  end

  assign valid_o = valid_q[3];
  assign res_o   = res_q;

endmodule

// ----- sv/magnetometer_heading.sv -----
// compass heading: one result per transaction; throughput one transaction per cycle while
// the skid entry is empty: prep stage, a chain of 28 cordic cells and four conversion
// stages, all advancing together, then an output register with a skid entry
// reset clears all valid flags, the skid entry and the three configuration registers
// depends on mh_pkg, mh_prep, mh_cell, mh_post
`timescale 1ns / 1ps

module magnetometer_heading import mh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // x_high_byte, x_low_byte, y_high_byte, y_low_byte
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // corrected_x, corrected_y, heading, zero pad
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RAW_W-1:0]     cfg_data_i
);

  localparam int unsigned OUT_W = 2 * RAW_W + HEAD_W;

  // configuration registers
  logic [RAW_W-1:0]  x_corr_q;
  logic [RAW_W-1:0]  y_corr_q;
  logic [RAW_W-1:0]  decl_q;
  logic [HEAD_W-1:0] decl_scaled_q;

  // pipeline control
  logic              en;
  cordic_t           chain [CORDIC_ITERATIONS+1];
  logic              post_valid;
  result_t           post_res;

  // output register and skid entry
  logic              out_valid_d;
  logic              out_valid_q;
  result_t           out_d;
  result_t           out_q;
  logic              skid_valid_d;
  logic              skid_valid_q;
  result_t           skid_d;
  result_t           skid_q;
  logic              pop;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_corr_q <= '0;
      y_corr_q <= '0;
      decl_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_X_CORR: x_corr_q <= cfg_data_i;
        REG_Y_CORR: y_corr_q <= cfg_data_i;
        REG_DECL:   decl_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // declination times 1000, kept ready for the last conversion stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_scaled_q <= '0;
    end else begin
      decl_scaled_q <= HEAD_W'(decl_q) * HEAD_W'(DECL_SCALE);
    end
  end

  // whole pipeline moves unless the skid entry is holding a result
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  mh_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .x_high_byte_i (s_axis_tdata[7:0]),
    .x_low_byte_i  (s_axis_tdata[15:8]),
    .y_high_byte_i (s_axis_tdata[23:16]),
    .y_low_byte_i  (s_axis_tdata[31:24]),
    .x_corr_i      (x_corr_q),
    .y_corr_i      (y_corr_q),
    .cell_o        (chain[0])
  );

  // cordic chain, cell g shifts by g and turns by atan(2^-g)
  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    localparam logic [Z_W-1:0] STEP_ANGLE = Z_W'(atan_pow2(g));

    mh_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (SH_W'(g)),
      .angle_i (STEP_ANGLE),
      .cell_i  (chain[g]),
      .cell_o  (chain[g+1])
    );
  end

  mh_post u_post (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .cell_i        (chain[CORDIC_ITERATIONS]),
    .decl_scaled_i (decl_scaled_q),
    .valid_o       (post_valid),
    .res_o         (post_res)
  );

  // output register refills from the skid entry first, else straight from the pipeline
  always_comb begin
    pop          = out_valid_q && m_axis_tready;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = post_valid;
        out_d       = post_res;
      end
    end else if (post_valid && en) begin
      // output stalled, park the arriving result
      skid_valid_d = 1'b1;
      skid_d       = post_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(64 - OUT_W)'(0), out_q.heading, out_q.corr_y, out_q.corr_x};

  // skid entry only holds data behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full with empty output register");

  // skid entry fills only after the output was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid entry filled without an output stall");

  // zero vector gives the declination term alone
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.corr_x == '0) && (out_q.corr_y == '0))
      |-> (out_q.heading == decl_scaled_q))
    else $error("zero vector heading differs from declination");

endmodule
